// ----- hw/rtl/mbd_pkg.sv -----
// Shared types, constants and helper functions for the block decryptor.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mbd_pkg;

   localparam int WORDS      = 4;
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);
   localparam int DIV_STAGES = 32;

   localparam logic [7:0] CHK_SEED = 8'hF8;
   localparam logic [7:0] LEN_MASK = 8'h3D;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_MOD_01 = 3'd0;
   localparam logic [2:0] REG_MOD_23 = 3'd1;
   localparam logic [2:0] REG_KEY_01 = 3'd2;
   localparam logic [2:0] REG_KEY_23 = 3'd3;
   localparam logic [2:0] REG_XOR_01 = 3'd4;
   localparam logic [2:0] REG_XOR_23 = 3'd5;

   typedef struct packed {
      logic [WORDS-1:0][31:0] modulus;
      logic [WORDS-1:0][31:0] key;
      logic [WORDS-1:0][31:0] xw;
   } cfg_type;

   typedef struct packed {
      logic [WORDS-1:0][31:0] prod;
      logic [WORDS-1:0][15:0] mix;
      logic [7:0]             length;
      logic [7:0]             chk_ref;
   } q_entry_type;

   typedef struct packed {
      logic [WORDS-1:0][31:0] rem;
      logic [WORDS-1:0][31:0] dvd;
      logic [WORDS-1:0][15:0] mix;
      logic [7:0]             length;
      logic [7:0]             chk_ref;
   } div_stage_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } q_status_type;

   // One restoring step: shift in one dividend bit, subtract when it fits.
   // A zero modulus subtracts nothing, so the dividend passes through.
   function automatic logic [31:0] div_step(input logic [31:0] rem,
                                            input logic bit_in,
                                            input logic [31:0] m);
      logic [32:0] r2;
      r2 = {rem, bit_in};
      if (r2 >= {1'b0, m}) begin
         r2 = r2 - {1'b0, m};
      end
      return r2[31:0];
   endfunction

endpackage

// ----- hw/rtl/modulus_block_decrypt.sv -----
// Simple-modulus 11-to-8 block decryptor: configuration registers, front end,
// queue and back end. Uses mbd_pkg, mbd_front, mbd_queue and mbd_back.
//
// Usage:
//   req_ channel: one beat per 11-byte cipher block (bytes 0..7 in tdata[63:0],
//   bytes 8..10 in tdata[87:64]). rsp_ channel: one beat per block with the
//   eight plain bytes and the length byte; tuser carries the checksum error.
//   csr_ port: APB-style writes of the six 64-bit modulus, key and xor
//   registers at byte address 8*i; the user writes them only while no block is in flight (not enforced by the block).
// Path: with no stall, the beat is written into the queue, stage 0 of the
//   one-bit-per-stage remainder pipeline then loads from the queue head, the
//   32 stages follow one another (one stage per product bit), and the output
//   register follows the last one.
// Throughput: one block per cycle while the output is not stalled; the four
//   remainder lanes are fully pipelined.
// Reset: clears the registers to zero, empties the queue and pipeline.
// Stall: a stalled output freezes the remainder pipeline; the four-entry queue
//   keeps taking beats until it fills, then req_tready drops.
`timescale 1ns / 1ps

module modulus_block_decrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // cipher_head[63:0], cipher_tail[87:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // plain_data[63:0], plain_length[71:64]
   output logic        rsp_tuser,   // checksum_error[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import mbd_pkg::*;

   logic [5:0][63:0] regs_ff;
   logic [2:0]       idx;
   logic             wr_en;
   cfg_type          cfg;
   q_entry_type      entry;
   q_entry_type      head;
   q_status_type     q_status;
   logic             push;
   logic             pop;

   // Register file
   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[5:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_MOD_01, REG_MOD_23, REG_KEY_01,
            REG_KEY_23, REG_XOR_01, REG_XOR_23: regs_ff[idx] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_MOD_01, REG_MOD_23, REG_KEY_01,
         REG_KEY_23, REG_XOR_01, REG_XOR_23: csr_prdata = regs_ff[idx];
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.modulus = {regs_ff[REG_MOD_23], regs_ff[REG_MOD_01]};
   assign cfg.key     = {regs_ff[REG_KEY_23], regs_ff[REG_KEY_01]};
   assign cfg.xw      = {regs_ff[REG_XOR_23], regs_ff[REG_XOR_01]};

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;

   mbd_front u_front (
      .req_tdata (req_tdata),
      .cfg       (cfg),
      .entry     (entry)
   );

   mbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   mbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_valid (!q_status.empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_reset_clears_out: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QDEPTH))
      else $error("queue count beyond depth");
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty together");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (q_status.count != '0))
      else $error("pop from empty queue");
`endif

endmodule

// ----- hw/rtl/mbd_front.sv -----
// Front end: unpacks the 88-bit cipher stream, unchains the words and forms
// the four key products and xor terms for one queue entry. Uses mbd_pkg.
`timescale 1ns / 1ps

module mbd_front (
   input  logic [87:0]          req_tdata,
   input  mbd_pkg::cfg_type     cfg,
   output mbd_pkg::q_entry_type entry
);
   import mbd_pkg::*;

   logic [10:0][7:0]       cb;
   logic [87:0]            s;
   logic [WORDS-1:0][31:0] w;
   logic [WORDS-1:0][31:0] u;

   assign cb = req_tdata;

   // Stream bit p is bit 7-(p%8) of byte p/8
   always_comb begin
      for (int p = 0; p < 88; p++) begin
         s[p] = cb[p / 8][7 - (p % 8)];
      end
   end

   // Gather the 18-bit words: low byte, high byte, bit 17, bit 16
   always_comb begin
      for (int n = 0; n < WORDS; n++) begin
         w[n] = '0;
         for (int i = 0; i < 8; i++) begin
            w[n][7 - i]  = s[18 * n + i];
            w[n][15 - i] = s[18 * n + 8 + i];
         end
         w[n][17] = s[18 * n + 16];
         w[n][16] = s[18 * n + 17];
      end
   end

   // Unchain words 2 down to 0
   always_comb begin
      u[3] = w[3];
      u[2] = w[2] ^ cfg.xw[2] ^ {16'h0, u[3][15:0]};
      u[1] = w[1] ^ cfg.xw[1] ^ {16'h0, u[2][15:0]};
      u[0] = w[0] ^ cfg.xw[0] ^ {16'h0, u[1][15:0]};
   end

   // Products wrap at 32 bits; xor term folds in the previous word
   always_comb begin
      for (int n = 0; n < WORDS; n++) begin
         entry.prod[n] = cfg.key[n] * u[n];
      end
      entry.mix[0] = cfg.xw[0][15:0];
      for (int n = 1; n < WORDS; n++) begin
         entry.mix[n] = cfg.xw[n][15:0] ^ u[n - 1][15:0];
      end
      entry.length  = cb[9] ^ cb[10] ^ LEN_MASK;
      entry.chk_ref = cb[10];
   end

endmodule

// ----- hw/rtl/mbd_queue.sv -----
// Short FIFO between front and back end, in flip-flops.
// Uses mbd_pkg for the entry and status types.
`timescale 1ns / 1ps

module mbd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mbd_pkg::q_entry_type push_entry,
   input  logic                 pop,
   output mbd_pkg::q_entry_type head,
   output mbd_pkg::q_status_type status
);
   import mbd_pkg::*;

   q_entry_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]       wr_ff, wr_in;
   logic [QPTR_W-1:0]       rd_ff, rd_in;
   logic [QCNT_W-1:0]       cnt_ff, cnt_in;

   assign head         = mem_ff[rd_ff];
   assign status.count = cnt_ff;
   assign status.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign status.empty = (cnt_ff == '0);

   // Advance pointers and count
   always_comb begin
      wr_in  = push ? QPTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? QPTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Hold entry data
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/mbd_back.sv -----
// Back end: 32-stage restoring remainder pipeline for four lanes, then the
// final xor, checksum and output register. Uses mbd_pkg.
`timescale 1ns / 1ps

module mbd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  mbd_pkg::cfg_type     cfg,
   input  mbd_pkg::q_entry_type head,
   input  logic                 head_valid,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,
   output logic                 rsp_tuser
);
   import mbd_pkg::*;

   div_stage_type             st_ff [DIV_STAGES];
   div_stage_type             st_in [DIV_STAGES];
   logic [DIV_STAGES-1:0]     vld_ff;
   logic                      adv;
   logic                      out_vld_ff;
   logic [63:0]               plain_ff, plain_in;
   logic [7:0]                len_ff;
   logic                      err_ff, err_in;

   // Whole pipeline moves while the output register is free
   assign adv = !out_vld_ff || rsp_tready;
   assign pop = adv && head_valid;

   // Stage 0 starts from the queue head, later stages from their neighbor
   always_comb begin
      st_in[0].mix     = head.mix;
      st_in[0].length  = head.length;
      st_in[0].chk_ref = head.chk_ref;
      for (int n = 0; n < WORDS; n++) begin
         st_in[0].rem[n] = div_step(32'h0, head.prod[n][31], cfg.modulus[n]);
         st_in[0].dvd[n] = {head.prod[n][30:0], 1'b0};
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         st_in[k].mix     = st_ff[k - 1].mix;
         st_in[k].length  = st_ff[k - 1].length;
         st_in[k].chk_ref = st_ff[k - 1].chk_ref;
         for (int n = 0; n < WORDS; n++) begin
            st_in[k].rem[n] = div_step(st_ff[k - 1].rem[n], st_ff[k - 1].dvd[n][31],
                                       cfg.modulus[n]);
            st_in[k].dvd[n] = {st_ff[k - 1].dvd[n][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], head_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // Finish plain words and checksum from the last stage
   always_comb begin
      logic [7:0] chk;
      for (int n = 0; n < WORDS; n++) begin
         plain_in[16 * n +: 16] = st_ff[DIV_STAGES-1].rem[n][15:0]
                                ^ st_ff[DIV_STAGES-1].mix[n];
      end
      chk = CHK_SEED;
      for (int i = 0; i < 8; i++) begin
         chk = chk ^ plain_in[8 * i +: 8];
      end
      err_in = (chk != st_ff[DIV_STAGES-1].chk_ref);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plain_ff <= plain_in;
         len_ff   <= st_ff[DIV_STAGES-1].length;
         err_ff   <= err_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {len_ff, plain_ff};
   assign rsp_tuser  = err_ff;

endmodule

// ----- tb/modulus_block_decrypt_test.sv -----
// Self-checking bench for modulus_block_decrypt: random and directed cipher blocks,
// APB register settings between phases, predicted plain blocks compared per beat.
// Depends on mbd_pkg and the block's RTL.
`timescale 1ns / 1ps

module modulus_block_decrypt_test;
   import mbd_pkg::*;

   typedef struct packed {
      logic [63:0] plain;
      logic [7:0]  length;
      logic        chk_err;
   } plain_block_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   modulus_block_decrypt DUT (.*);

   logic [63:0]     key_regs [6];
   logic [87:0]     cipher_q [$];
   plain_block_type plain_q [$];
   int  errors = 0;
   int  blocks_in = 0, blocks_out = 0;
   int  send_idle_pct = 0, recv_stall_pct = 0;
   bit  hold_rsp = 0;
   int  quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] reg_word(int base, int n);
      logic [63:0] r;
      r = key_regs[base + n / 2];
      return (n % 2) ? r[63:32] : r[31:0];
   endfunction

   // Decrypt one cipher block the way the block should.
   function automatic plain_block_type decrypt_block(logic [87:0] c);
      logic [87:0]     s;
      logic [31:0]     w [4];
      logic [31:0]     prod, m, red, prev, xv;
      logic [63:0]     plain;
      logic [7:0]      chk;
      logic [7:0]      t0, t1;
      int              p;
      plain_block_type r;
      // Build the MSB-first stream: byte 0 is the top byte.
      for (int i = 0; i < 11; i++) s[87 - 8*i -: 8] = c[8*i +: 8];
      for (int n = 0; n < 4; n++) begin
         p = 87 - 18*n;
         w[n] = {14'd0, s[p-16], s[p-17], s[p-8 -: 8], s[p -: 8]};
      end
      for (int n = 2; n >= 0; n--)
         w[n] = w[n] ^ reg_word(4, n) ^ {16'd0, w[n+1][15:0]};
      prev = 0;
      plain = 0;
      for (int n = 0; n < 4; n++) begin
         prod = reg_word(2, n) * w[n];
         m = reg_word(0, n);
         red = (m != 0) ? prod % m : prod;
         xv = reg_word(4, n);
         plain[16*n +: 16] = red[15:0] ^ xv[15:0] ^ prev[15:0];
         prev = {16'd0, w[n][15:0]};
      end
      t0 = c[79:72];
      t1 = c[87:80];
      chk = CHK_SEED;
      for (int i = 0; i < 8; i++) chk ^= plain[8*i +: 8];
      r.plain = plain;
      r.length = t0 ^ t1 ^ LEN_MASK;
      r.chk_err = (chk != t1);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   // Driver: offer queued cipher blocks, idling at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            plain_q.push_back(decrypt_block(req_tdata));
            blocks_in++;
         end
         if (!req_tvalid || req_tready) begin
            if (cipher_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata  <= cipher_q.pop_front();
               req_tvalid <= 1;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // Monitor: check each result beat, stall at random.
   always @(posedge clock) begin
      plain_block_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            blocks_out++;
            if (plain_q.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata[63:0], 64'd0);
            end else begin
               e = plain_q.pop_front();
               if (rsp_tdata[63:0] !== e.plain)
                  report_mismatch("plain_data", rsp_tdata[63:0], e.plain);
               if (rsp_tdata[71:64] !== e.length)
                  report_mismatch("plain_length", 64'(rsp_tdata[71:64]), 64'(e.length));
               if (rsp_tuser !== e.chk_err)
                  report_mismatch("checksum_error", 64'(rsp_tuser), 64'(e.chk_err));
            end
         end
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: count cycles with no beat on either channel and no register access.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("timeout");
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(int idx, logic [63:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= 6'(8 * idx); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx < 6) key_regs[idx] = val;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Wait until every queued block is sent and every result has come back.
   task automatic drain();
      while (cipher_q.size() > 0 || req_tvalid || plain_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [63:0] mod_pick();
      case ($urandom_range(4))
         0: return 0;
         1: return '1;
         2: return {$urandom_range(1, 300), 32'($urandom_range(1, 300))};
         default: return rand64();
      endcase
   endfunction

   initial begin
      for (int i = 0; i < 6; i++) key_regs[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 0;

      // Directed: zero registers, then extremes, then mixed.
      cipher_q.push_back('0);
      cipher_q.push_back('1);
      drain();
      write_reg(REG_MOD_01, '1); write_reg(REG_MOD_23, '1);
      write_reg(REG_KEY_01, '1); write_reg(REG_KEY_23, '1);
      write_reg(REG_XOR_01, '1); write_reg(REG_XOR_23, '1);
      cipher_q.push_back('0);
      cipher_q.push_back('1);
      cipher_q.push_back({8'h55, 80'h0});
      for (int i = 0; i < 88; i += 8) cipher_q.push_back(88'hFF << i);
      drain();
      write_reg(REG_MOD_01, {32'd0, 32'd7}); write_reg(REG_MOD_23, {32'd3, 32'd0});
      write_reg(REG_KEY_01, rand64()); write_reg(REG_KEY_23, rand64());
      write_reg(REG_XOR_01, 0); write_reg(REG_XOR_23, rand64());
      for (int i = 0; i < 8; i++) cipher_q.push_back({$urandom, rand64()});
      drain();

      // Random phases under the four idling patterns, long stall in the first.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         write_reg(REG_MOD_01, mod_pick()); write_reg(REG_MOD_23, mod_pick());
         write_reg(REG_KEY_01, rand64()); write_reg(REG_KEY_23, rand64());
         write_reg(REG_XOR_01, rand64()); write_reg(REG_XOR_23, rand64());
         for (int i = 0; i < 110; i++) cipher_q.push_back({$urandom, rand64()});
         if (ph == 0) begin
            fork
               begin
                  hold_rsp = 1;
                  repeat (200) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         drain();
      end
      send_idle_pct = 0; recv_stall_pct = 0;

      $display("blocks sent %0d, results checked %0d, over eleven register settings",
               blocks_in, blocks_out);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
hw/rtl/mbd_pkg.sv
hw/rtl/mbd_front.sv
hw/rtl/mbd_queue.sv
hw/rtl/mbd_back.sv
hw/rtl/modulus_block_decrypt.sv
tb/modulus_block_decrypt_test.sv
